[rtl/b64sd_pkg.sv]
// Package for the Base64 stream decoder: payload types, status codes,
// character constants and the alphabet lookup. No dependencies.
package b64sd_pkg;

  // Status code carried on every result
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } b64sd_status_e;

  // One request on the character channel
  typedef struct packed {
    logic [20:0] symbol;
    logic        has_symbol;
    logic        end_of_text;
  } b64sd_sym_t;

  // One request on the result channel
  typedef struct packed {
    logic [7:0]    data_byte;
    logic          byte_valid;
    b64sd_status_e status;
    logic          last_of_text;
  } b64sd_res_t;

  // Character codes
  localparam logic [20:0] CH_PAD   = 21'h00003D;
  localparam logic [20:0] CH_MINUS = 21'h00002D;
  localparam logic [20:0] CH_UNDER = 21'h00005F;
  localparam logic [20:0] CH_PLUS  = 21'h00002B;
  localparam logic [20:0] CH_SLASH = 21'h00002F;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  // Most results one character can cause
  localparam int unsigned MAX_RES = 3;
  // Result queue depth (power of two)
  localparam int unsigned RES_DEPTH = 8;

  // Sextet value 0..63 of a character, 64 when outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [20:0] ch, input logic url);
    logic [6:0] v;
    v = 7'd64;
    if (ch >= 21'h41 && ch <= 21'h5A) begin
      v = 7'(ch - 21'h41);
    end else if (ch >= 21'h61 && ch <= 21'h7A) begin
      v = 7'(ch - 21'h61 + 21'd26);
    end else if (ch >= 21'h30 && ch <= 21'h39) begin
      v = 7'(ch - 21'h30 + 21'd52);
    end else if (url && ch == CH_MINUS) begin
      v = 7'd62;
    end else if (url && ch == CH_UNDER) begin
      v = 7'd63;
    end else if (!url && ch == CH_PLUS) begin
      v = 7'd62;
    end else if (!url && ch == CH_SLASH) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

[rtl/b64sd_stream_if.sv]
// Valid/ready stream interface used by both channels of the decoder.
// The payload type is a parameter; depends on nothing else.
interface b64sd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/base64_stream_decoder_top.sv]
// Channel    Dir  Payload                                   Handshake
// in_if      in   symbol[20:0], has_symbol, end_of_text     valid/ready
// out_if     out  data_byte[7:0], byte_valid, status, last  valid/ready
// cfg        in   cfg_wdata_i = url_alphabet                cfg_we_i, no stall
//
// One character is decoded in the cycle it is accepted; its up to three
// results go into an 8-entry result queue and leave one per cycle unless
// stalled, the first in the next cycle. in_if.ready is high while the queue
// has room for three results, so characters flow at one per cycle as long as
// the sink keeps pace: three results per four characters in long texts, up to
// one per character for short texts and end markers. Reset is asynchronous,
// active low, clears the decoder state, the queue and the alphabet select.
// Base64 stream decoder top level; uses b64sd_pkg and b64sd_stream_if.

module base64_stream_decoder_top
  import b64sd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  b64sd_stream_if.sink   in_if,
  b64sd_stream_if.source out_if
);

  localparam int unsigned PtrW = $clog2(RES_DEPTH);
  localparam int unsigned CntW = $clog2(RES_DEPTH + 1);
  localparam logic [CntW-1:0] ReadyMax = CntW'(RES_DEPTH - MAX_RES);

  // Decoder state
  logic        url_q;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  gc_q, gc_d;
  logic [2:0]  pad_q, pad_d;
  logic        err_q, err_d;

  // Result queue
  b64sd_res_t        res_mem_q [RES_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  b64sd_sym_t  req;
  logic        accept, pop;
  b64sd_res_t  res [MAX_RES];
  logic [1:0]  n_res;

  // Decode working signals
  logic        proc, is_pad, ch_ok, grp_done;
  logic [6:0]  sxt;
  logic [23:0] acc_sh, acc_e;
  logic [2:0]  pad_new;
  logic [1:0]  nb;

  assign req    = in_if.data;
  assign accept = in_if.valid && in_if.ready;
  assign pop    = out_if.valid && out_if.ready;

  assign in_if.ready  = (cnt_q <= ReadyMax);
  assign out_if.valid = (cnt_q != '0);
  assign out_if.data  = res_mem_q[rd_ptr_q];

  // Alphabet select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
    end else if (cfg_we_i) begin
      url_q <= cfg_wdata_i;
    end
  end

  // Character decode, state update and result build
  always_comb begin
    proc     = req.has_symbol && !err_q;
    is_pad   = !url_q && (req.symbol == CH_PAD);
    sxt      = sextet_of(req.symbol, url_q);
    ch_ok    = is_pad || !sxt[6];
    acc_sh   = {acc_q[17:0], (is_pad ? 6'd0 : sxt[5:0])};
    pad_new  = (is_pad && pad_q < 3'd4) ? pad_q + 3'd1 : pad_q;
    grp_done = proc && ch_ok && (gc_q == 2'd3);
    if (url_q || pad_new == 3'd0) begin
      nb = 2'd3;
    end else if (pad_new == 3'd1) begin
      nb = 2'd2;
    end else begin
      nb = 2'd1;
    end

    acc_d = acc_q;
    gc_d  = gc_q;
    pad_d = pad_q;
    err_d = err_q;
    n_res = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '{data_byte: 8'd0, byte_valid: 1'b0, status: ST_OK, last_of_text: 1'b0};
    end

    // one character into the group
    if (proc) begin
      if (!ch_ok) begin
        err_d = 1'b1;
      end else if (grp_done) begin
        acc_d = '0;
        gc_d  = 2'd0;
        pad_d = 3'd0;
        n_res = nb;
        res[0].data_byte  = acc_sh[23:16] & BYTE_MASK;
        res[0].byte_valid = 1'b1;
        res[1].data_byte  = acc_sh[15:8] & BYTE_MASK;
        res[1].byte_valid = 1'b1;
        res[2].data_byte  = acc_sh[7:0] & BYTE_MASK;
        res[2].byte_valid = 1'b1;
      end else begin
        acc_d = acc_sh;
        gc_d  = gc_q + 2'd1;
        pad_d = pad_new;
      end
    end

    // end of text: flush, report, clear
    acc_e = (gc_d == 2'd2) ? {acc_d[11:0], 12'd0} : {acc_d[17:0], 6'd0};
    if (req.end_of_text) begin
      if (err_d) begin
        n_res = 2'd1;
        res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, status: ST_INVALID,
                   last_of_text: 1'b0};
      end else if (gc_d != 2'd0) begin
        if (url_q && gc_d >= 2'd2) begin
          n_res = gc_d - 2'd1;
          res[0].data_byte  = acc_e[23:16];
          res[0].byte_valid = 1'b1;
          res[1].data_byte  = acc_e[15:8];
          res[1].byte_valid = 1'b1;
        end else begin
          n_res = 2'd1;
          res[0].status = ST_INCOMPLETE;
        end
      end
      if (n_res == 2'd0) begin
        n_res = 2'd1;
      end
      case (n_res)
        2'd1:    res[0].last_of_text = 1'b1;
        2'd2:    res[1].last_of_text = 1'b1;
        2'd3:    res[2].last_of_text = 1'b1;
        default: res[0].last_of_text = 1'b1;
      endcase
      acc_d = '0;
      gc_d  = 2'd0;
      pad_d = 3'd0;
      err_d = 1'b0;
    end

    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = cnt_d + CntW'(n_res);
    end
    if (pop) begin
      cnt_d = cnt_d - CntW'(1);
    end
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      gc_q  <= '0;
      pad_q <= '0;
      err_q <= 1'b0;
    end else if (accept) begin
      acc_q <= acc_d;
      gc_q  <= gc_d;
      pad_q <= pad_d;
      err_q <= err_d;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (k < int'(n_res)) begin
          res_mem_q[wr_ptr_q + PtrW'(k)] <= res[k];
        end
      end
    end
  end

endmodule

[rtl/b64sd_checker.sv]
// Port-level checks for the Base64 stream decoder, bound to the top level.
// Uses b64sd_pkg for the status codes.
module b64sd_checker
  import b64sd_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [7:0]    out_data_byte,
  input logic          out_byte_valid,
  input b64sd_status_e out_status,
  input logic          out_last
);

  // a result waiting is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // byte results always carry ok status
  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_byte_valid |-> out_status == ST_OK)
    else $error("byte result with error status");

  // non-byte results carry a zero byte
  a_nobyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_byte_valid |-> out_data_byte == 8'd0)
    else $error("data_byte set without byte_valid");

  // error reports only close a text
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error status not on last result");

  // input stalls only while results are queued
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

endmodule

bind base64_stream_decoder_top b64sd_checker u_b64sd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_data_byte  (out_if.data.data_byte),
  .out_byte_valid (out_if.data.byte_valid),
  .out_status     (out_if.data.status),
  .out_last       (out_if.data.last_of_text)
);
